// ===== rtl/unescape_ascii_to_utf16_defines.svh =====
// assertion macros for the escaped byte stream decoder
// used by the top level only, no other dependencies
`ifndef UNESCAPE_ASCII_TO_UTF16_DEFINES_SVH
`define UNESCAPE_ASCII_TO_UTF16_DEFINES_SVH

// same-cycle implication, checked out of reset
`define UATU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uatu same-cycle check failed");

// next-cycle implication, checked out of reset
`define UATU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uatu next-cycle check failed");

`endif

// ===== rtl/uatu_pkg.sv =====
// shared types and constants for the escaped byte stream decoder
// no dependencies
package uatu_pkg;

  localparam int unsigned HexDigitsDef = 4;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned CodeWidth = 16;
  localparam logic [7:0] EscByte = 8'h78;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusBadDigit  = 2'd1,
    StatusTruncated = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CodeWidth-1:0] code_unit;
    status_e              status;
    logic                 end_of_stream;
  } out_item_t;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic       is_esc;
    logic       hex_ok;
    logic [3:0] nibble;
    logic [7:0] raw_byte;
    logic       last_byte;
  } entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

// ===== rtl/uatu_stream_if.sv =====
// valid/ready channel carrying one payload item per handshake
// payload type given by the instantiating module
interface uatu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/uatu_front.sv =====
// front: accepts input bytes and classifies them (escape, hex digit value)
// depends on uatu_pkg and uatu_stream_if
module uatu_front import uatu_pkg::*; (
  uatu_stream_if.sink in_i,
  input  q_stat_t     q_stat_i,
  output logic        push_o,
  output entry_t      entry_o
);

  logic [7:0] b;
  logic       is_dec;
  logic       is_lc;
  logic       is_uc;
  logic [7:0] nib_wide;

  assign b      = in_i.data.data_byte;
  assign is_dec = (b >= 8'h30) && (b <= 8'h39);
  assign is_lc  = (b >= 8'h61) && (b <= 8'h66);
  assign is_uc  = (b >= 8'h41) && (b <= 8'h46);

  always_comb begin
    nib_wide = 8'd0;
    if (is_dec) begin
      nib_wide = b - 8'h30;
    end else if (is_lc) begin
      nib_wide = b - 8'h57;
    end else if (is_uc) begin
      nib_wide = b - 8'h37;
    end
  end

  assign in_i.ready = !q_stat_i.full;
  assign push_o     = in_i.valid && !q_stat_i.full;

  assign entry_o.is_esc    = (b == EscByte);
  assign entry_o.hex_ok    = is_dec || is_lc || is_uc;
  assign entry_o.nibble    = nib_wide[3:0];
  assign entry_o.raw_byte  = b;
  assign entry_o.last_byte = in_i.data.last_byte;

endmodule

// ===== rtl/uatu_queue.sv =====
// short fifo of classified bytes between front and back
// depends on uatu_pkg
module uatu_queue import uatu_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  entry_t  entry_i,
  input  logic    pop_i,
  output entry_t  entry_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  entry_t          slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o          = slot_q[rd_ptr_q];
  assign stat_o.not_empty = (count_q != '0);
  assign stat_o.full      = (count_q == CntW'(Depth));

endmodule

// ===== rtl/uatu_back.sv =====
// back: escape sequencing, hex accumulation and the registered result
// depends on uatu_pkg and uatu_stream_if
module uatu_back import uatu_pkg::*; #(
  parameter int unsigned HexDigits = HexDigitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  entry_t        entry_i,
  input  q_stat_t       q_stat_i,
  output logic          pop_o,
  uatu_stream_if.source out_o
);

  localparam int unsigned PhW = $clog2(HexDigits + 1);
  localparam logic [PhW-1:0] PhIdle = '0;
  localparam logic [PhW-1:0] PhEsc  = PhW'(1);
  localparam logic [PhW-1:0] PhLast = PhW'(HexDigits);

  logic [PhW-1:0]       phase_q, phase_d;
  logic [CodeWidth-1:0] acc_q, acc_d;
  logic                 bad_q, bad_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic                 emit;
  logic [CodeWidth-1:0] acc_sh;
  logic                 bad_sh;

  assign pop_o  = q_stat_i.not_empty && (!out_valid_q || out_o.ready);
  assign acc_sh = {acc_q[CodeWidth-5:0], entry_i.hex_ok ? entry_i.nibble : 4'd0};
  assign bad_sh = bad_q || !entry_i.hex_ok;

  always_comb begin
    phase_d           = phase_q;
    acc_d             = acc_q;
    bad_d             = bad_q;
    emit              = 1'b0;
    out_d             = out_q;
    out_d.status      = StatusOk;
    out_d.code_unit   = '0;
    out_d.end_of_stream = entry_i.last_byte;
    if (phase_q == PhIdle) begin
      if (entry_i.is_esc) begin
        phase_d = PhEsc;
        acc_d   = '0;
        bad_d   = 1'b0;
      end else begin
        emit            = 1'b1;
        out_d.code_unit = {{(CodeWidth-8){1'b0}}, entry_i.raw_byte};
      end
    end else if ((phase_q == PhEsc) && entry_i.is_esc) begin
      // doubled escape gives the escape character itself
      emit            = 1'b1;
      out_d.code_unit = {{(CodeWidth-8){1'b0}}, EscByte};
      phase_d         = PhIdle;
    end else begin
      acc_d = acc_sh;
      bad_d = bad_sh;
      if (phase_q >= PhLast) begin
        emit    = 1'b1;
        phase_d = PhIdle;
        if (bad_sh) begin
          out_d.status = StatusBadDigit;
        end else begin
          out_d.code_unit = acc_sh;
        end
      end else begin
        phase_d = phase_q + PhW'(1);
      end
    end
    // end of stream inside an escape
    if (entry_i.last_byte) begin
      phase_d = PhIdle;
      acc_d   = '0;
      bad_d   = 1'b0;
      if (!emit) begin
        emit            = 1'b1;
        out_d.status    = StatusTruncated;
        out_d.code_unit = '0;
      end
    end
  end

  always_comb begin
    if (pop_o) begin
      out_valid_d = emit;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      acc_q       <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        bad_q   <= bad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ===== rtl/unescape_ascii_to_utf16.sv =====
// escaped byte stream to 16-bit code unit decoder, top level
// depends on uatu_pkg, uatu_stream_if, uatu_front, uatu_queue, uatu_back
// and the assertion macros in unescape_ascii_to_utf16_defines.svh
//
// Takes one byte per item with a last-byte mark and gives zero or one 16-bit
// code unit per byte. A plain byte passes through as its own value, "xx"
// gives a literal 'x', and 'x' with HexDigits hex digits (either case) gives
// their value; a bad digit gives code 0 with status 1, and a stream that ends
// inside an escape gives code 0 with status 2 on its last byte. The block takes
// one byte every cycle when the output side keeps up; each byte is held in the
// queue and its result is then registered in the output register. The back
// end's decode step retires one queued byte per cycle while the output is
// free or being taken; the input side runs ahead by up to QueueDepth bytes
// while the output is stalled.
`include "unescape_ascii_to_utf16_defines.svh"

module unescape_ascii_to_utf16 import uatu_pkg::*; #(
  parameter int unsigned HexDigits  = HexDigitsDef,
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  uatu_stream_if.sink   in_i,
  uatu_stream_if.source out_o
);

  // front to queue
  logic    push;
  entry_t  push_entry;
  // queue to back
  entry_t  head_entry;
  q_stat_t q_stat;
  logic    pop;
  // result flags watched by the checks
  logic    out_trunc;
  logic    out_err;

  // classify incoming bytes; ready follows queue space only
  uatu_front u_front (
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  // decouples the byte intake from output stalls
  uatu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .stat_o  (q_stat)
  );

  // escape sequencing and result register
  uatu_back #(
    .HexDigits (HexDigits)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (head_entry),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

  assign out_trunc = out_o.valid && (out_o.data.status == StatusTruncated);
  assign out_err   = out_o.valid && (out_o.data.status != StatusOk);

  // a truncation result only ever comes from the last byte
  `UATU_ASSERT_NOW(a_trunc_is_eos, clk_i, rst_ni, out_trunc, out_o.data.end_of_stream)

  // any error status carries a zero code unit
  `UATU_ASSERT_NOW(a_err_zero_code, clk_i, rst_ni, out_err, out_o.data.code_unit == '0)

  // a byte taken into an empty queue is there to decode next cycle
  `UATU_ASSERT_NEXT(a_push_visible, clk_i, rst_ni, push && !q_stat.not_empty, q_stat.not_empty)

endmodule
